// ===== rtl/crc64be_pkg.sv =====
// ----------------------------------------------------------------------------
// crc64be_pkg
// Constants and the byte fold function for the reflected CRC-64 (ISO) engine.
// ----------------------------------------------------------------------------
package crc64be_pkg;

  localparam int unsigned CrcWidth  = 64;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] CrcPoly = 64'hd800_0000_0000_0000;

  // Folds one byte into the CRC, LSB first: eight shift/xor steps.
  function automatic logic [CrcWidth-1:0] crc_fold(
    input logic [CrcWidth-1:0]  acc,
    input logic [ByteWidth-1:0] data
  );
    logic [CrcWidth-1:0] r;
    r = acc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int k = 0; k < ByteWidth; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/crc64be_intf.sv =====
// ----------------------------------------------------------------------------
// crc64be channel interfaces
// Valid/ready channels carrying input bytes and CRC result items.
// ----------------------------------------------------------------------------
interface crc64be_in_if;
  logic                               valid;
  logic                               ready;
  logic [crc64be_pkg::ByteWidth-1:0]  data_byte;
  logic                               first_byte;
  logic                               last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface crc64be_out_if;
  logic                               valid;
  logic                               ready;
  logic [crc64be_pkg::CrcWidth-1:0]   crc_value;
  logic                               is_final;

  modport source (output valid, output crc_value, output is_final, input ready);
  modport sink   (input valid, input crc_value, input is_final, output ready);
endinterface

// ===== rtl/crc64_byte_engine.sv =====
// ----------------------------------------------------------------------------
// crc64_byte_engine
// Reflected CRC-64 (ISO polynomial), one byte per item, no final xor.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered in the input stage, then folded into the result register.
// Throughput: one item per cycle while the result channel is not stalled, set by the
// single-byte xor network between the input register and the result register.
// Reset: accumulator cleared to zero, both stages emptied.
// ----------------------------------------------------------------------------
module crc64_byte_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  crc64be_in_if.sink             in_i,
  crc64be_out_if.source          out_o
);

  logic                                s1_valid_q;
  logic [crc64be_pkg::ByteWidth-1:0]   s1_data_q;
  logic                                s1_first_q;
  logic                                s1_last_q;

  logic [crc64be_pkg::CrcWidth-1:0]    acc_q;
  logic [crc64be_pkg::CrcWidth-1:0]    acc_d;
  logic [crc64be_pkg::CrcWidth-1:0]    acc_base;

  logic                                out_valid_q;
  logic                                out_valid_d;
  logic [crc64be_pkg::CrcWidth-1:0]    out_crc_q;
  logic                                out_final_q;

  logic                                s1_adv;
  logic                                in_acc;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  assign acc_base = s1_first_q ? '0 : acc_q;
  assign acc_d    = crc64be_pkg::crc_fold(acc_base, s1_data_q);

  always_comb begin
    priority if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q  <= in_i.data_byte;
      s1_first_q <= in_i.first_byte;
      s1_last_q  <= in_i.last_byte;
    end
    if (s1_adv) begin
      out_crc_q   <= acc_d;
      out_final_q <= s1_last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;
  assign out_o.is_final  = out_final_q;

endmodule

// ===== rtl/crc64be_checker.sv =====
// ----------------------------------------------------------------------------
// crc64be_checker
// Port-level checks on the CRC-64 engine, bound to the top level.
// ----------------------------------------------------------------------------
module crc64be_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [crc64be_pkg::CrcWidth-1:0]   out_crc_i,
  input logic                               out_final_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_crc_i) && $stable(out_final_i))
    else $error("result changed while stalled");

  // a fresh result follows an item taken into the input stage
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result without a matching item");

  // a sink that takes results never stalls the input side
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  // empty result register means the input stage can take an item
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output empty");

endmodule

bind crc64_byte_engine crc64be_checker u_crc64be_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_crc_i   (out_o.crc_value),
  .out_final_i (out_o.is_final)
);

// ===== test/tb_crc64_byte_engine.sv =====
// ----------------------------------------------------------------------------
// tb_crc64_byte_engine
// Self-checking bench for the reflected CRC-64 (ISO) byte engine: byte items
// go in over the input channel, each one's running CRC and final flag is
// predicted here and compared against the result channel in order.
// ----------------------------------------------------------------------------
module tb_crc64_byte_engine;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxReports    = 100;

  typedef logic [crc64be_pkg::ByteWidth-1:0] data_byte_t;

  typedef struct packed {
    logic [crc64be_pkg::CrcWidth-1:0] crc;
    logic                             fin;
  } crc_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  crc64be_in_if  in_ch ();
  crc64be_out_if out_ch ();

  crc64_byte_engine uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  crc_result_t                      crc_expected_q[$];
  logic [crc64be_pkg::CrcWidth-1:0] crc_running;
  int unsigned                      send_idle_pct = 0;
  int unsigned                      recv_idle_pct = 0;
  int unsigned                      hold_left     = 0;
  int unsigned                      err_count     = 0;

  always begin
    #(ClkPeriod / 2) clk = 1'b1;
    #(ClkPeriod / 2) clk = 1'b0;
  end

  // Bit-serial fold, LSB first: feedback is the CRC's bit 0 xor the data bit.
  function automatic logic [crc64be_pkg::CrcWidth-1:0] next_crc(
    input logic [crc64be_pkg::CrcWidth-1:0] crc,
    input data_byte_t                       b
  );
    logic [crc64be_pkg::CrcWidth-1:0] c;
    logic                             fb;
    c = crc;
    for (int i = 0; i < crc64be_pkg::ByteWidth; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[crc64be_pkg::CrcWidth-1:1]} ^ (fb ? crc64be_pkg::CrcPoly : '0);
    end
    return c;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input data_byte_t b, input logic is_first,
                           input logic is_last);
    crc_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= is_first;
    in_ch.last_byte  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (is_first) crc_running = '0;
    crc_running = next_crc(crc_running, b);
    r.crc = crc_running;
    r.fin = is_last;
    crc_expected_q.push_back(r);
    @(negedge clk);
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    crc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (crc_expected_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: unexpected item, expected none, actual crc=%h final=%b",
                   $time, out_ch.crc_value, out_ch.is_final);
      end else begin
        want = crc_expected_q.pop_front();
        if (out_ch.crc_value !== want.crc) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("%0t: crc_value mismatch, expected %h, actual %h",
                     $time, want.crc, out_ch.crc_value);
        end
        if (out_ch.is_final !== want.fin) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("%0t: is_final mismatch, expected %b, actual %b",
                     $time, want.fin, out_ch.is_final);
        end
      end
    end
  end

  task automatic test_directed();
    data_byte_t check_str[9];
    check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // one-byte messages at the byte extremes
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    // standard check string
    for (int k = 0; k < 9; k++) send_byte(check_str[k], k == 0, k == 8);
    // no start after a last byte: carries on from the digest
    send_byte(8'h5a, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);
    // restart mid-message, twice running
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  // Mostly framed messages with random content, some loose bytes.
  task automatic test_random_messages(input int unsigned n_items, input int unsigned s_pct,
                                      input int unsigned r_pct);
    int unsigned sent;
    int unsigned len;
    sent          = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 33) : $urandom_range(16, 1);
        for (int k = 0; k < len; k++)
          send_byte(data_byte_t'($urandom_range(255)), k == 0, k == len - 1);
        sent += len;
      end else begin
        send_byte(data_byte_t'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // Receiver stops for a long stretch while bytes keep coming.
  task automatic test_input_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 300;
    for (int k = 0; k < 40; k++)
      send_byte(data_byte_t'($urandom_range(255)), k % 10 == 0, k % 10 == 9);
  endtask

  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    crc_running      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_messages(630, 25, 84);
    test_random_messages(630, 84, 25);
    test_random_messages(630, 0, 0);
    test_input_stall();

    in_ch.valid <= 1'b0;
    recv_idle_pct = 0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc64be_pkg.sv
rtl/crc64be_intf.sv
rtl/crc64_byte_engine.sv
rtl/crc64be_checker.sv
test/tb_crc64_byte_engine.sv
